FILE: hw/rtl/assert_macros.svh
// Assertion macros used by drdb_checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, held off while reset is asserted.
`define DRDB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also covers the reset cycles.
`define DRDB_ASSERT_NORST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/drdb_pkg.sv
package drdb_pkg;

  // Field widths of the request and result formats, configuration and random source
  localparam int SET_W   = 11;
  localparam int WAY_W   = 4;
  localparam int SEL_W   = 10;
  localparam int DECAY_W = 20;
  localparam int LEAD_W  = 11;
  localparam int CFG_W   = 20;
  localparam int LFSR_W  = 16;

  // Request modes
  localparam logic MODE_QUERY  = 1'b0;
  localparam logic MODE_UPDATE = 1'b1;

  // Configuration register reset values
  localparam logic [DECAY_W-1:0] DECAY_PERIOD_RST = 20'd100000;
  localparam logic [LEAD_W-1:0]  LEADER_SETS_RST  = 11'd32;

  // Per-way state encodings
  localparam logic [1:0] RRPV_NEAR    = 2'd0;
  localparam logic [1:0] RRPV_LONG    = 2'd2;
  localparam logic [1:0] RRPV_DISTANT = 2'd3;
  localparam logic [1:0] DEAD_ZERO    = 2'd0;
  localparam logic [1:0] DEAD_FILL    = 2'd2;
  localparam logic [1:0] DEAD_MAX     = 2'd3;

  // Random source
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [0:0] {
    CFG_DECAY_PERIOD,
    CFG_LEADER_SETS
  } drdb_cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECAY,
    ST_READ,
    ST_EXEC
  } drdb_state_t;

  typedef struct packed {
    logic             mode;
    logic [SET_W-1:0] set_index;
    logic [WAY_W-1:0] way_index;
    logic             was_hit;
    logic             victim_valid;
  } drdb_in_t;

  typedef struct packed {
    logic [WAY_W-1:0] victim_way;
    logic             used_srrip;
    logic [SEL_W-1:0] selector_value;
  } drdb_out_t;

  // Classified request handed from front to back
  typedef struct packed {
    logic             mode;
    logic [SET_W-1:0] set;
    logic [WAY_W-1:0] way;
    logic             was_hit;
    logic             victim_valid;
    logic             srrip_lead;
    logic             brrip_lead;
    logic             decay;
  } drdb_cmd_t;

  // Status of the random insertion draw
  typedef struct packed {
    logic ready;
    logic long_ins;
  } drdb_rnd_t;

  function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
    logic [LFSR_W-1:0] n;
    n = v >> 1;
    if (v[0]) n = n ^ LFSR_TAPS;
    return n;
  endfunction

endpackage

FILE: hw/rtl/drrip_dead_block_replacement_top.sv
// DRRIP replacement state with dead-block detection for one set-associative cache.
// Requests enter through a queue-style port: drive in_data and raise in_push; the
// request is taken at a clock edge where in_full is low. mode 0 asks for a victim
// way of a set, mode 1 records a hit or a miss fill. Every request gives one result,
// read from out_data while out_empty is low and removed with out_pop.
// Configuration (decay period, leader set count) is written through cfg_we,
// cfg_index and cfg_data while no request is in flight.
// A request passes the front stage, command queue, row read and search before its
// result enters the result queue and shows on out_data. The back end takes one
// request at a time (row read, then search and write-back); a BRRIP fill right
// after another waits for the next random draw. When the update counter reaches
// the decay period, the request first runs a deadness sweep over every set, then
// rereads its row; the row memory's single read and single write port pace it.
// Reset: after rst_n the block clears the row memory for NUM_SETS cycles and holds
// in_full high meanwhile; the result queue starts empty.
// When the receiver stalls, two results wait in the output queue, one request in the
// back end, two in the command queue and one in the front stage; then in_full rises.
module drrip_dead_block_replacement_top #(
  parameter int NUM_SETS         = 2048,
  parameter int NUM_WAYS         = 16,
  parameter int SELECTOR_MAX     = 1023,
  parameter int LONG_INSERT_ODDS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  drdb_pkg::drdb_in_t          in_data,
  output logic                        out_empty,
  input  logic                        out_pop,
  output drdb_pkg::drdb_out_t         out_data,
  input  logic                        cfg_we,
  input  drdb_pkg::drdb_cfg_idx_t     cfg_index,
  input  logic [drdb_pkg::CFG_W-1:0]  cfg_data
);
  import drdb_pkg::*;

  logic      clearing;
  logic      cmd_push, cmd_full, cmd_pop, cmd_empty;
  drdb_cmd_t cmd_in, cmd_out;
  logic      res_push, res_full;
  drdb_out_t res_in;
  drdb_rnd_t rnd_status;
  logic      rnd_adv;

  drdb_front #(
    .NUM_SETS (NUM_SETS),
    .NUM_WAYS (NUM_WAYS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .cmd_full  (cmd_full),
    .cmd_push  (cmd_push),
    .cmd_data  (cmd_in)
  );

  drdb_fifo #(
    .WIDTH ($bits(drdb_cmd_t)),
    .DEPTH (2)
  ) u_cmd_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cmd_push),
    .push_data (cmd_in),
    .full      (cmd_full),
    .pop       (cmd_pop),
    .pop_data  (cmd_out),
    .empty     (cmd_empty)
  );

  drdb_rand #(
    .LONG_INSERT_ODDS (LONG_INSERT_ODDS)
  ) u_rand (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (rnd_adv),
    .status  (rnd_status)
  );

  drdb_back #(
    .NUM_SETS     (NUM_SETS),
    .NUM_WAYS     (NUM_WAYS),
    .SELECTOR_MAX (SELECTOR_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmd_empty),
    .cmd_data  (cmd_out),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res_data  (res_in),
    .rnd       (rnd_status),
    .rnd_adv   (rnd_adv),
    .clearing  (clearing)
  );

  drdb_fifo #(
    .WIDTH ($bits(drdb_out_t)),
    .DEPTH (2)
  ) u_res_q (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_in),
    .full      (res_full),
    .pop       (out_pop),
    .pop_data  (out_data),
    .empty     (out_empty)
  );

endmodule

FILE: hw/rtl/drdb_fifo.sv
module drdb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);
  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full     = (count_r == CntW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the pushed entry
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: hw/rtl/drdb_front.sv
module drdb_front #(
  parameter int NUM_SETS = 2048,
  parameter int NUM_WAYS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  drdb_pkg::drdb_in_t      in_data,
  input  logic                    cfg_we,
  input  drdb_pkg::drdb_cfg_idx_t cfg_index,
  input  logic [drdb_pkg::CFG_W-1:0] cfg_data,
  input  logic                    clearing,
  input  logic                    cmd_full,
  output logic                    cmd_push,
  output drdb_pkg::drdb_cmd_t     cmd_data
);
  import drdb_pkg::*;

  // Reciprocal constants for the set and way reductions
  localparam int     SetShift  = SET_W + $clog2(NUM_SETS);
  localparam longint SetMul    = ((longint'(1) << SetShift) + NUM_SETS - 1) / NUM_SETS;
  localparam int     SetMulW   = $clog2(SetMul + 1);
  localparam int     SetProdW  = SET_W + SetMulW;
  localparam int     WayShift  = WAY_W + $clog2(NUM_WAYS);
  localparam longint WayMul    = ((longint'(1) << WayShift) + NUM_WAYS - 1) / NUM_WAYS;
  localparam int     WayMulW   = $clog2(WayMul + 1);
  localparam int     WayProdW  = WAY_W + WayMulW;

  logic [DECAY_W-1:0]  decay_period_r, decay_period_nxt;
  logic [LEAD_W-1:0]   leader_sets_r, leader_sets_nxt;
  logic [DECAY_W-1:0]  tick_r, tick_nxt;
  logic                s1_vld_r, s1_vld_nxt;
  drdb_in_t            s1_item_r;
  logic [SetProdW-1:0] set_prod_r;
  logic [WayProdW-1:0] way_prod_r;

  logic                accept, move;
  logic [SetProdW-1:0] q_set;
  logic [WayProdW-1:0] q_way;
  logic [SET_W-1:0]    set_mod;
  logic [WAY_W-1:0]    way_mod;
  logic                srrip_c, brrip_c, decay_c;
  logic [DECAY_W:0]    tick_inc;

  assign in_full  = clearing || (s1_vld_r && cmd_full);
  assign accept   = in_push && !in_full;
  assign move     = s1_vld_r && !cmd_full;
  assign cmd_push = move;

  // Reduce set and way, classify leaders, count updates toward decay
  always_comb begin
    q_set    = SetProdW'(set_prod_r >> SetShift);
    q_way    = WayProdW'(way_prod_r >> WayShift);
    set_mod  = s1_item_r.set_index - SET_W'(q_set * NUM_SETS);
    way_mod  = s1_item_r.way_index - WAY_W'(q_way * NUM_WAYS);
    srrip_c  = set_mod < leader_sets_r;
    brrip_c  = !srrip_c && (leader_sets_r != '0) &&
               ((32'(set_mod) + 32'(leader_sets_r)) >= 32'(NUM_SETS));
    tick_inc = {1'b0, tick_r} + 1'b1;
    decay_c  = (s1_item_r.mode == MODE_UPDATE) && (tick_inc >= {1'b0, decay_period_r});

    cmd_data.mode         = s1_item_r.mode;
    cmd_data.set          = set_mod;
    cmd_data.way          = way_mod;
    cmd_data.was_hit      = s1_item_r.was_hit;
    cmd_data.victim_valid = s1_item_r.victim_valid;
    cmd_data.srrip_lead   = srrip_c;
    cmd_data.brrip_lead   = brrip_c;
    cmd_data.decay        = decay_c;

    tick_nxt = tick_r;
    if (move && s1_item_r.mode == MODE_UPDATE) begin
      tick_nxt = decay_c ? '0 : tick_inc[DECAY_W-1:0];
    end

    s1_vld_nxt = s1_vld_r;
    if (accept) begin
      s1_vld_nxt = 1'b1;
    end else if (move) begin
      s1_vld_nxt = 1'b0;
    end
  end

  // Take configuration writes
  always_comb begin
    decay_period_nxt = decay_period_r;
    leader_sets_nxt  = leader_sets_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DECAY_PERIOD: decay_period_nxt = cfg_data[DECAY_W-1:0];
        CFG_LEADER_SETS:  leader_sets_nxt  = cfg_data[LEAD_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_period_r <= DECAY_PERIOD_RST;
      leader_sets_r  <= LEADER_SETS_RST;
      tick_r         <= '0;
      s1_vld_r       <= 1'b0;
    end else begin
      decay_period_r <= decay_period_nxt;
      leader_sets_r  <= leader_sets_nxt;
      tick_r         <= tick_nxt;
      s1_vld_r       <= s1_vld_nxt;
    end
  end

  // Capture the request and start the reciprocal products
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r  <= in_data;
      set_prod_r <= SetProdW'(in_data.set_index) * SetProdW'(SetMul);
      way_prod_r <= WayProdW'(in_data.way_index) * WayProdW'(WayMul);
    end
  end

endmodule

FILE: hw/rtl/drdb_rand.sv
module drdb_rand #(
  parameter int LONG_INSERT_ODDS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                advance,
  output drdb_pkg::drdb_rnd_t status
);
  import drdb_pkg::*;

  // Exact reciprocal for a 16-bit dividend
  localparam int     RShift = LFSR_W + $clog2(LONG_INSERT_ODDS);
  localparam longint RMul   = ((longint'(1) << RShift) + LONG_INSERT_ODDS - 1) /
                              LONG_INSERT_ODDS;
  localparam int     RMulW  = $clog2(RMul + 1);
  localparam int     ProdW  = LFSR_W + RMulW;

  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic              vld1_r, vld2_r;
  logic [LFSR_W-1:0] val1_r;
  logic [ProdW-1:0]  prod_r;
  logic              long_r;
  logic [LFSR_W-1:0] draw_c;
  logic [ProdW-1:0]  quot_c;

  assign draw_c   = lfsr_step(lfsr_r);
  assign lfsr_nxt = advance ? draw_c : lfsr_r;
  assign quot_c   = ProdW'(prod_r >> RShift);

  assign status.ready    = vld2_r;
  assign status.long_ins = long_r;

  // Drop precomputed draws whenever the register advances
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_SEED;
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
    end else begin
      lfsr_r <= lfsr_nxt;
      vld1_r <= !advance;
      vld2_r <= vld1_r && !advance;
    end
  end

  // Check the next draw for a zero remainder over two stages
  always_ff @(posedge clk) begin
    val1_r <= draw_c;
    prod_r <= ProdW'(draw_c) * ProdW'(RMul);
    long_r <= (val1_r == LFSR_W'(quot_c * LONG_INSERT_ODDS));
  end

endmodule

FILE: hw/rtl/drdb_back.sv
module drdb_back #(
  parameter int NUM_SETS     = 2048,
  parameter int NUM_WAYS     = 16,
  parameter int SELECTOR_MAX = 1023
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cmd_empty,
  input  drdb_pkg::drdb_cmd_t cmd_data,
  output logic                cmd_pop,
  input  logic                res_full,
  output logic                res_push,
  output drdb_pkg::drdb_out_t res_data,
  input  drdb_pkg::drdb_rnd_t rnd,
  output logic                rnd_adv,
  output logic                clearing
);
  import drdb_pkg::*;

  localparam int AW   = $clog2(NUM_SETS);
  localparam int WW   = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int RowW = 4 * NUM_WAYS;
  localparam int PW   = $clog2(SELECTOR_MAX + 1);
  localparam int CntW = AW + 1;
  localparam logic [RowW-1:0] INIT_ROW = {NUM_WAYS{RRPV_DISTANT, DEAD_FILL}};

  // One row per set: way w holds RRPV in [4w+3:4w+2], deadness in [4w+1:4w]
  logic [RowW-1:0] row_mem_r [NUM_SETS];
  logic [RowW-1:0] rd_row_r;

  drdb_state_t     state_r, state_nxt;
  logic [CntW-1:0] ptr_r, ptr_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  drdb_cmd_t       cmd_r, cmd_nxt;
  logic [PW-1:0]   psel_r, psel_nxt;

  logic            mem_we, mem_re;
  logic [AW-1:0]   mem_waddr, mem_raddr;
  logic [RowW-1:0] mem_wdata;

  logic [NUM_WAYS-1:0] dead0_v, rr3_v, rr2_v;
  logic [WW-1:0]       wi, victim;
  logic [1:0]          old_dead;
  logic                srrip_pick, need_rnd, go;
  logic [1:0]          ins_rrpv;

  function automatic logic [WW-1:0] first_set(input logic [NUM_WAYS-1:0] v);
    logic [WW-1:0] idx;
    idx = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (v[w]) idx = WW'(w);
    end
    return idx;
  endfunction

  function automatic logic [RowW-1:0] row_decay(input logic [RowW-1:0] row);
    logic [RowW-1:0] res;
    res = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row[4*w +: 2] != DEAD_ZERO) res[4*w +: 2] = row[4*w +: 2] - 2'd1;
    end
    return res;
  endfunction

  function automatic logic [RowW-1:0] row_age(input logic [RowW-1:0] row);
    logic [RowW-1:0] res;
    res = row;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (row[4*w+2 +: 2] != RRPV_DISTANT) res[4*w+2 +: 2] = row[4*w+2 +: 2] + 2'd1;
    end
    return res;
  endfunction

  assign clearing = (state_r == ST_CLEAR);

  // Classify the ways of the row that was read
  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      dead0_v[w] = (rd_row_r[4*w +: 2] == DEAD_ZERO);
      rr3_v[w]   = (rd_row_r[4*w+2 +: 2] == RRPV_DISTANT);
      rr2_v[w]   = (rd_row_r[4*w+2 +: 2] == RRPV_LONG);
    end
    wi         = WW'(cmd_r.way);
    old_dead   = rd_row_r[4*wi +: 2];
    srrip_pick = cmd_r.srrip_lead ||
                 (!cmd_r.brrip_lead && (psel_r >= PW'(SELECTOR_MAX / 2)));
    need_rnd   = (cmd_r.mode == MODE_UPDATE) && !cmd_r.was_hit && !srrip_pick;
    ins_rrpv   = (srrip_pick || rnd.long_ins) ? RRPV_LONG : RRPV_DISTANT;
    go         = !res_full && (!need_rnd || rnd.ready);
  end

  // Sequence clear, decay sweep, row read and execution
  always_comb begin
    state_nxt     = state_r;
    ptr_nxt       = ptr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cmd_nxt       = cmd_r;
    psel_nxt      = psel_r;
    cmd_pop       = 1'b0;
    res_push      = 1'b0;
    rnd_adv       = 1'b0;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_waddr     = pend_addr_r;
    mem_raddr     = AW'(cmd_r.set);
    mem_wdata     = rd_row_r;
    victim        = '0;

    case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr_r[AW-1:0];
        mem_wdata = INIT_ROW;
        ptr_nxt   = ptr_r + 1'b1;
        if (ptr_r[AW-1:0] == AW'(NUM_SETS - 1)) begin
          ptr_nxt   = '0;
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd_data;
          if (cmd_data.decay) begin
            ptr_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = ST_DECAY;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = AW'(cmd_data.set);
            state_nxt = ST_EXEC;
          end
        end
      end

      ST_DECAY: begin
        // Read one row and write back the previous one each cycle
        if (ptr_r != CntW'(NUM_SETS)) begin
          mem_re        = 1'b1;
          mem_raddr     = ptr_r[AW-1:0];
          ptr_nxt       = ptr_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_addr_nxt = ptr_r[AW-1:0];
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = pend_addr_r;
          mem_wdata = row_decay(rd_row_r);
        end
        if (ptr_r == CntW'(NUM_SETS) && !pend_r) begin
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(cmd_r.set);
        state_nxt = ST_EXEC;
      end

      ST_EXEC: begin
        mem_waddr = AW'(cmd_r.set);
        if (go) begin
          res_push  = 1'b1;
          state_nxt = ST_IDLE;
          if (cmd_r.mode == MODE_QUERY) begin
            if (|dead0_v) begin
              victim = first_set(dead0_v);
            end else if (|rr3_v) begin
              victim = first_set(rr3_v);
            end else begin
              // Age the set once, then take the first way that reached distant, else way 0
              mem_we    = 1'b1;
              mem_wdata = row_age(rd_row_r);
              victim    = (|rr2_v) ? first_set(rr2_v) : '0;
            end
          end else begin
            mem_we = 1'b1;
            if (cmd_r.was_hit) begin
              mem_wdata[4*wi+2 +: 2] = RRPV_NEAR;
              if (old_dead != DEAD_MAX) begin
                mem_wdata[4*wi +: 2] = old_dead + 2'd1;
              end
            end else begin
              mem_wdata[4*wi+2 +: 2] = ins_rrpv;
              mem_wdata[4*wi +: 2]   = DEAD_FILL;
              rnd_adv                = !srrip_pick;
              // Train the selector on leader evictions of live blocks
              if (cmd_r.victim_valid && old_dead != DEAD_ZERO) begin
                if (cmd_r.srrip_lead && psel_r < PW'(SELECTOR_MAX)) begin
                  psel_nxt = psel_r + 1'b1;
                end else if (cmd_r.brrip_lead && psel_r != '0) begin
                  psel_nxt = psel_r - 1'b1;
                end
              end
            end
          end
        end
      end

      default: state_nxt = ST_CLEAR;
    endcase

    res_data.victim_way     = WAY_W'(victim);
    res_data.used_srrip     = (cmd_r.mode == MODE_UPDATE) && !cmd_r.was_hit && srrip_pick;
    res_data.selector_value = SEL_W'(psel_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      ptr_r   <= '0;
      pend_r  <= 1'b0;
      psel_r  <= PW'(SELECTOR_MAX / 2);
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      pend_r  <= pend_nxt;
      psel_r  <= psel_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    cmd_r       <= cmd_nxt;
  end

  // Row memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem_r[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_row_r <= row_mem_r[mem_raddr];
    end
  end

endmodule

FILE: hw/rtl/drdb_checker.sv
`include "assert_macros.svh"

module drdb_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input drdb_pkg::drdb_out_t out_data
);

  // Hold off requests while the row memory is cleared after reset
  `DRDB_ASSERT_NORST(a_clear_blocks_requests, clk, !rst_n |=> in_full, "request port open during clear")

  // Start with no results after reset
  `DRDB_ASSERT_NORST(a_reset_drops_results, clk, !rst_n |=> out_empty, "result present after reset")

  // Keep a waiting result in place until it is popped
  `DRDB_ASSERT(a_result_holds, clk, rst_n, (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)), "waiting result changed")

endmodule

bind drrip_dead_block_replacement_top drdb_checker u_drdb_checker (.*);
